// ----- rtl/sensor_scratchpad_checker_unit_assert.svh -----
// Assertion macros for the scratchpad checker.
`ifndef SENSOR_SCRATCHPAD_CHECKER_UNIT_ASSERT_SVH
`define SENSOR_SCRATCHPAD_CHECKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, quiet during reset.
`define SCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scp assertion failed");
// Next-cycle implication, sampled on clk, quiet during reset.
`define SCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scp assertion failed");
`else
`define SCP_ASSERT_NOW(lbl, ante, cons)
`define SCP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/scp_pkg.sv -----
// Shared types, constants, a CRC helper and a resolution mask helper for the scratchpad checker.
package scp_pkg;

  localparam logic [3:0]        ScratchLast     = 4'd8;
  localparam logic [3:0]        PosTempLsb      = 4'd0;
  localparam logic [3:0]        PosTempMsb      = 4'd1;
  localparam logic [3:0]        PosAlarmHigh    = 4'd2;
  localparam logic [3:0]        PosConfig       = 4'd4;
  localparam int unsigned       ResShift        = 5;
  localparam logic [7:0]        CrcPolyReflect  = 8'h8C;
  localparam logic signed [15:0] DisconnectedRst = 16'shE480;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_SENS_RST = 2'd2,
    ST_FAULT    = 2'd3
  } status_t;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] scratch_byte;
    logic       frame_start;
    logic       bus_fault;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic signed [15:0] temperature;
    status_t            status;
  } result_t;

  // Handshake between the check core and its neighbor stages
  typedef struct packed {
    logic take;     // core consumes the held input beat
    logic res_load; // core hands a result to the output register
  } core_ctl_t;

  // Low bits of the temperature LSB to clear for each resolution
  function automatic logic [7:0] low_clear_mask(input logic [1:0] res);
    logic [7:0] m;
    begin
      unique case (res)
        2'd0: m = 8'h07;
        2'd1: m = 8'h03;
        2'd2: m = 8'h01;
        2'd3: m = 8'h00;
      endcase
      return m;
    end
  endfunction

  // Reflected 1-Wire CRC-8 over one byte, LSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] acc,
                                             input logic [7:0] data);
    logic [7:0] a;
    logic [7:0] d;
    logic       mix;
    begin
      a = acc;
      d = data;
      for (int i = 0; i < 8; i++) begin
        mix = a[0] ^ d[0];
        a   = {1'b0, a[7:1]};
        if (mix) begin
          a = a ^ CrcPolyReflect;
        end
        d   = {1'b0, d[7:1]};
      end
      return a;
    end
  endfunction

endpackage

// ----- rtl/scp_stream_ifs.sv -----
// Valid/ready channel interfaces for scratchpad bytes and results.
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scratch_byte;
  logic       frame_start;
  logic       bus_fault;

  modport source (output valid, output scratch_byte, output frame_start,
                  output bus_fault, input ready);
  modport sink   (input valid, input scratch_byte, input frame_start,
                  input bus_fault, output ready);
endinterface

interface scp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic [1:0]         status;

  modport source (output valid, output temperature, output status, input ready);
  modport sink   (input valid, input temperature, input status, output ready);
endinterface

// ----- rtl/sensor_scratchpad_checker_unit.sv -----
// Top level of the scratchpad checker: stages, config register, checks.
//
//   channel   dir  payload                                  handshake
//   in_beat   in   scratch_byte[7:0] frame_start bus_fault  valid/ready
//   out_beat  out  temperature[15:0] status[1:0]            valid/ready
//   cfg       in   cfg_wdata[15:0] disconnected_value       cfg_we
//
// One byte beat is accepted per cycle, except behind a stalled result beat;
// bytes 0 to 7 give no result. A result beat (byte 8 or a bus fault) passes
// the input register to the check core, which loads the output register.
// A stalled output holds only beats that produce a result; other bytes flow.
// Synchronous active-low reset clears the frame count, CRC and valid flags.
`include "sensor_scratchpad_checker_unit_assert.svh"

module sensor_scratchpad_checker_unit
  import scp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  scp_in_if.sink             in_beat,
  scp_out_if.source          out_beat,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);

  logic signed [15:0] disc_value_r;
  in_beat_t           in_pay;
  in_beat_t           held_beat;
  logic               held_vld;
  logic               out_free;
  core_ctl_t          ctl;
  result_t            res;

  // Hold the disconnected value register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_value_r <= DisconnectedRst;
    end else if (cfg_we) begin
      disc_value_r <= cfg_wdata;
    end
  end

  assign in_pay.scratch_byte = in_beat.scratch_byte;
  assign in_pay.frame_start  = in_beat.frame_start;
  assign in_pay.bus_fault    = in_beat.bus_fault;

  scp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_beat.valid),
    .in_ready  (in_beat.ready),
    .in_beat   (in_pay),
    .take      (ctl.take),
    .held_vld  (held_vld),
    .held_beat (held_beat)
  );

  scp_check_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_vld   (held_vld),
    .beat       (held_beat),
    .out_free   (out_free),
    .disc_value (disc_value_r),
    .ctl        (ctl),
    .res        (res)
  );

  scp_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (ctl.res_load),
    .res             (res),
    .out_free        (out_free),
    .out_valid       (out_beat.valid),
    .out_ready       (out_beat.ready),
    .out_temperature (out_beat.temperature),
    .out_status      (out_beat.status)
  );

  // Check: a result never overwrites a pending beat
  `SCP_ASSERT_NOW(a_load_when_free, ctl.res_load, out_free)
  // Check: core takes only a held beat
  `SCP_ASSERT_NOW(a_take_needs_beat, ctl.take, held_vld)
  // Check: a held beat that is not taken stays held
  `SCP_ASSERT_NEXT(a_held_stays, held_vld && !ctl.take, held_vld)
  // Check: a taken fault shows up as a fault result next cycle
  `SCP_ASSERT_NEXT(a_fault_result, ctl.take && held_beat.bus_fault,
                   out_beat.valid && (out_beat.status == 2'(ST_FAULT)))

endmodule

// ----- rtl/scp_in_stage.sv -----
// Input register: holds one scratchpad beat until the core takes it.
module scp_in_stage
  import scp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  input  logic     take,
  output logic     held_vld,
  output in_beat_t held_beat
);

  logic     vld_r, vld_nxt;
  in_beat_t beat_r;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign held_vld  = vld_r;
  assign held_beat = beat_r;

endmodule

// ----- rtl/scp_check_core.sv -----
// Frame tracking, CRC-8 accumulation, byte capture and result decision.
module scp_check_core
  import scp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_vld,
  input  in_beat_t           beat,
  input  logic               out_free,
  input  logic signed [15:0] disc_value,
  output core_ctl_t          ctl,
  output result_t            res
);

  logic [3:0] byte_count_r, byte_count_nxt;
  logic [7:0] crc_acc_r, crc_acc_nxt;
  logic [7:0] temp_low_r;
  logic [7:0] temp_high_r;
  logic [7:0] alarm_high_r;
  logic [1:0] res_bits_r;

  logic [3:0] pos;
  logic [7:0] crc_base;
  logic       is_last;
  logic       need_res;
  logic       take;
  logic [7:0] lsb_kept;

  // Restart on frame start or on a count past the last byte
  always_comb begin
    if (beat.frame_start || (byte_count_r > ScratchLast)) begin
      pos      = 4'd0;
      crc_base = 8'h00;
    end else begin
      pos      = byte_count_r;
      crc_base = crc_acc_r;
    end
  end

  assign is_last  = (pos == ScratchLast);
  assign need_res = beat.bus_fault || is_last;
  // Stall only beats that produce a result while the output is full
  assign take     = beat_vld && (!need_res || out_free);

  assign ctl.take     = take;
  assign ctl.res_load = take && need_res;

  // Advance count and CRC
  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_acc_nxt    = crc_acc_r;
    if (take) begin
      if (beat.bus_fault || is_last) begin
        byte_count_nxt = 4'd0;
        crc_acc_nxt    = 8'h00;
      end else begin
        byte_count_nxt = 4'(pos + 4'd1);
        crc_acc_nxt    = crc8_update(crc_base, beat.scratch_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 4'd0;
      crc_acc_r    <= 8'h00;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_acc_r    <= crc_acc_nxt;
    end
  end

  // Capture temperature, alarm-high and resolution bytes
  always_ff @(posedge clk) begin
    if (take && !beat.bus_fault) begin
      if (pos == PosTempLsb)   temp_low_r   <= beat.scratch_byte;
      if (pos == PosTempMsb)   temp_high_r  <= beat.scratch_byte;
      if (pos == PosAlarmHigh) alarm_high_r <= beat.scratch_byte;
      if (pos == PosConfig)    res_bits_r   <= beat.scratch_byte[ResShift +: 2];
    end
  end

  assign lsb_kept = temp_low_r & ~low_clear_mask(res_bits_r);

  // Pick the result: fault, then CRC, then reset marker
  always_comb begin
    priority if (beat.bus_fault) begin
      res.temperature = disc_value;
      res.status      = ST_FAULT;
    end else if (crc_base != beat.scratch_byte) begin
      res.temperature = disc_value;
      res.status      = ST_CRC_ERR;
    end else if (alarm_high_r == 8'h00) begin
      res.temperature = disc_value;
      res.status      = ST_SENS_RST;
    end else begin
      res.temperature = {temp_high_r, lsb_kept};
      res.status      = ST_OK;
    end
  end

endmodule

// ----- rtl/scp_out_stage.sv -----
// Output register: holds one result beat until the sink takes it.
module scp_out_stage
  import scp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  result_t            res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature,
  output logic [1:0]         out_status
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign out_free = !vld_r || out_ready;

  // Set on load, drop once the sink takes the beat
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = vld_r;
  assign out_temperature = res_r.temperature;
  assign out_status      = 2'(res_r.status);

endmodule
